// ----- sv/snsh_pkg.sv -----
package snsh_pkg;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  localparam logic [3:0] CHAR_POS_MAX = 4'd14;
  localparam logic [3:0] PREFIX_END = 4'd13;
  localparam logic [1:0] DOT_MAX = 2'd2;

  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [2:0] REG_BASE_SEED     = 3'd0;
  localparam logic [2:0] REG_DOMAIN_VALUE  = 3'd1;
  localparam logic [2:0] REG_PROCESS_VALUE = 3'd2;
  localparam logic [2:0] REG_TICK_VALUE    = 3'd3;
  localparam logic [2:0] REG_MIX_SELECT    = 3'd4;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       last_byte;
  } name_req_t;

  typedef struct packed {
    logic [31:0] seed;
    logic        name_ok;
  } seed_rsp_t;

  function automatic logic [31:0] fold64(input logic [63:0] v);
    return v[31:0] ^ v[63:32];
  endfunction

  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "n";
      4'd1:    c = "o";
      4'd2:    c = "i";
      4'd3:    c = "s";
      4'd4:    c = "e";
      4'd5:    c = ".";
      4'd6:    c = "s";
      4'd7:    c = "t";
      4'd8:    c = "r";
      4'd9:    c = "e";
      4'd10:   c = "a";
      4'd11:   c = "m";
      4'd12:   c = ".";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/stream_name_seed_hash_unit.sv -----
// Stream name seed hash unit.
// Name channel (name_valid, name_stall, name_data): one byte of a stream name
// per request, last_byte set on the final byte. Seed channel (seed_valid,
// seed_stall, seed_data): one result per name, carrying the derived seed and
// the name_ok flag for the naming rules.
// Throughput is one byte per cycle; the FNV-1a step (XOR, constant multiply)
// and the rule checks sit between the name state and the result register.
// Latency: the result is on the seed channel in the cycle after the last byte
// is accepted, unless an earlier result is still waiting on a stalled receiver.
// The result side holds two entries, an output register and a skid register,
// so bytes keep flowing while one result waits. name_stall is high only while
// the skid register is occupied, i.e. after the receiver has held seed_stall
// with one result pending and a second name has finished.
// Reset clears the name state to the FNV offset basis, empties both result
// entries and zeroes all configuration registers.
// Configuration: APB port, registers at byte address 8*index: 64-bit
// base seed, domain, process, tick, 4-bit mix select. Write only while idle.
module stream_name_seed_hash_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                name_valid,
  output logic                                name_stall,
  input  snsh_pkg::name_req_t                 name_data,
  output logic                                seed_valid,
  input  logic                                seed_stall,
  output snsh_pkg::seed_rsp_t                 seed_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [snsh_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [snsh_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [snsh_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic [63:0] base_seed;
  logic [63:0] domain_value;
  logic [63:0] process_value;
  logic [63:0] tick_value;
  logic [3:0]  mix_select;

  logic [31:0] running_hash;
  logic [3:0]  char_position;
  logic        name_broken;
  logic        segment_nonempty;
  logic [1:0]  dot_count;

  logic [31:0] running_hash_next;
  logic [3:0]  char_position_next;
  logic        name_broken_next;
  logic        segment_nonempty_next;
  logic [1:0]  dot_count_next;

  logic                out_valid;
  snsh_pkg::seed_rsp_t out_data;
  logic                skid_valid;
  snsh_pkg::seed_rsp_t skid_data;

  logic                name_accept;
  logic                push;
  logic                out_take;
  logic                cfg_write;
  logic [2:0]          cfg_index;
  snsh_pkg::seed_rsp_t result;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign cfg_index  = paddr[5:3];

  assign name_stall  = skid_valid;
  assign name_accept = name_valid && !name_stall;
  assign push        = name_accept && name_data.last_byte;
  assign out_take    = out_valid && !seed_stall;
  assign seed_valid  = out_valid;
  assign seed_data   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seed     <= '0;
      domain_value  <= '0;
      process_value <= '0;
      tick_value    <= '0;
      mix_select    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        snsh_pkg::REG_BASE_SEED:     base_seed     <= pwdata;
        snsh_pkg::REG_DOMAIN_VALUE:  domain_value  <= pwdata;
        snsh_pkg::REG_PROCESS_VALUE: process_value <= pwdata;
        snsh_pkg::REG_TICK_VALUE:    tick_value    <= pwdata;
        snsh_pkg::REG_MIX_SELECT:    mix_select    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      snsh_pkg::REG_BASE_SEED:     prdata = base_seed;
      snsh_pkg::REG_DOMAIN_VALUE:  prdata = domain_value;
      snsh_pkg::REG_PROCESS_VALUE: prdata = process_value;
      snsh_pkg::REG_TICK_VALUE:    prdata = tick_value;
      snsh_pkg::REG_MIX_SELECT:    prdata = {60'b0, mix_select};
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  lc;
    logic        allowed;
    logic [31:0] mix;
    b  = name_data.name_byte;
    lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    allowed = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
              (b >= "0" && b <= "9") || b == "-" || b == "_";

    running_hash_next     = (running_hash ^ {24'b0, b}) * snsh_pkg::FNV_PRIME;
    name_broken_next      = name_broken;
    segment_nonempty_next = segment_nonempty;
    dot_count_next        = dot_count;

    if (char_position < snsh_pkg::PREFIX_END) begin
      if (lc != snsh_pkg::prefix_char(char_position)) begin
        name_broken_next = 1'b1;
      end
    end else if (b == ".") begin
      if (!segment_nonempty) begin
        name_broken_next = 1'b1;
      end
      if (dot_count < snsh_pkg::DOT_MAX) begin
        dot_count_next = dot_count + 2'd1;
      end
      segment_nonempty_next = 1'b0;
    end else if (allowed) begin
      segment_nonempty_next = 1'b1;
    end else begin
      name_broken_next = 1'b1;
    end

    char_position_next = (char_position < snsh_pkg::CHAR_POS_MAX) ?
                         char_position + 4'd1 : char_position;

    mix = snsh_pkg::fold64(base_seed);
    if (mix_select[0]) mix = mix ^ snsh_pkg::fold64(domain_value);
    if (mix_select[1]) mix = mix ^ snsh_pkg::fold64(process_value);
    if (mix_select[2]) mix = mix ^ snsh_pkg::fold64(tick_value);
    if (mix_select[3]) mix = mix ^ running_hash_next;

    result.seed    = mix;
    result.name_ok = !name_broken_next &&
                     char_position_next == snsh_pkg::CHAR_POS_MAX &&
                     segment_nonempty_next &&
                     dot_count_next == snsh_pkg::DOT_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash     <= snsh_pkg::FNV_BASIS;
      char_position    <= '0;
      name_broken      <= 1'b0;
      segment_nonempty <= 1'b0;
      dot_count        <= '0;
    end else if (name_accept) begin
      if (name_data.last_byte) begin
        running_hash     <= snsh_pkg::FNV_BASIS;
        char_position    <= '0;
        name_broken      <= 1'b0;
        segment_nonempty <= 1'b0;
        dot_count        <= '0;
      end else begin
        running_hash     <= running_hash_next;
        char_position    <= char_position_next;
        name_broken      <= name_broken_next;
        segment_nonempty <= segment_nonempty_next;
        dot_count        <= dot_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || out_take) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_take |=> out_valid && !skid_valid)
    else $error("skid entry did not move to the output register");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("last byte accepted but no result pending");

  a_last_clears_state: assert property (@(posedge clk) disable iff (rst)
    push |=> running_hash == snsh_pkg::FNV_BASIS && char_position == 4'd0 &&
             dot_count == 2'd0 && !name_broken && !segment_nonempty)
    else $error("name state not cleared after last byte");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    char_position <= snsh_pkg::CHAR_POS_MAX && dot_count <= snsh_pkg::DOT_MAX)
    else $error("name counters beyond saturation");
`endif

endmodule
